// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ===== rtl/trmd_pkg.sv =====
// Package: shared types and constants of the trace ring merge drain unit
`default_nettype none
package trmd_pkg;
    localparam int unsigned CNT_W = 48;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam int unsigned ENTRY_W = 64 + 64 + 64 + 12;
    typedef enum logic {MODE_RECORD = 1'b0, MODE_DRAIN = 1'b1} mode_t;
endpackage
`default_nettype wire

// ===== rtl/trmd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read
`default_nettype none
module trmd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/trace_ring_merge_drain_unit.sv =====
// Top level: per-core trace rings in one RAM with a timestamp-ordered drain
`default_nettype none
`include "assert_macros.svh"
// A record item is written straight into the ring RAM unless a drain has
// started or its slot's count is saturated. An enabled drain item scans, picks
// and emits its result. The scan reads the head of every slot through the
// single RAM read port, one slot a cycle, with a registered read. It then
// reads the earliest entry back and registers it. The first drain also
// latches the cursors and totals of every slot first. The input stalls from
// the acceptance of a drain until its result is registered. It also stalls
// while a held result is stalled. No clearing pass is needed after reset.
module trace_ring_merge_drain_unit #(
    parameter int unsigned CORES      = 8,
    parameter int unsigned RING_DEPTH = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               mode,
    input  wire logic signed [7:0]  core,
    input  wire logic [63:0]        timestamp,
    input  wire logic [63:0]        actor,
    input  wire logic [3:0]         kind,
    input  wire logic signed [31:0] message_type,
    input  wire logic signed [31:0] sender,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    is_summary,
    output logic [63:0]             out_time,
    output logic signed [7:0]       out_core,
    output logic [63:0]             out_actor,
    output logic [3:0]              out_kind,
    output logic signed [31:0]      out_message_type,
    output logic signed [31:0]      out_sender,
    output logic [47:0]             event_total,
    output logic [47:0]             drop_total
);
    localparam int unsigned SLOTS  = CORES + 1;
    localparam int unsigned SLOT_W = $clog2(SLOTS + 1);
    localparam int unsigned POS_W  = $clog2(RING_DEPTH);
    localparam int unsigned DEPTH  = SLOTS * RING_DEPTH;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CW     = trmd_pkg::CNT_W;
    localparam logic [CW-1:0] RD   = CW'(RING_DEPTH);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(RING_DEPTH - 1);

    typedef enum logic [2:0] {S_IDLE, S_LATCH, S_SCAN, S_PICK, S_EMIT} state_t;

    state_t state_reg;
    logic enable_reg, started_reg, done_reg;
    logic [CW-1:0] wcount_reg [SLOTS];
    logic [CW-1:0] cursor_reg [SLOTS];
    logic [CW-1:0] end_reg [SLOTS];
    logic [POS_W-1:0] wptr_reg [SLOTS];
    logic [POS_W-1:0] rptr_reg [SLOTS];
    logic [CW-1:0] tot_ev_reg, tot_dr_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic scan_pend_reg;
    logic [SLOT_W-1:0] pend_slot_reg;
    logic best_vld_reg;
    logic [SLOT_W-1:0] best_slot_reg;
    logic [63:0] best_ts_reg;

    logic in_acc, out_acc, out_free, is_rec;
    logic [SLOT_W-1:0] slot;
    logic [CW-1:0] cnt_sel;
    logic [POS_W-1:0] wptr_sel, wptr_idx, rptr_idx, rptr_best;
    logic rec_we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [trmd_pkg::ENTRY_W-1:0] wdata, rdata;
    logic re;

    assign out_free = !out_valid || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || (!out_free);
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid && !out_stall;
    assign is_rec   = (mode == trmd_pkg::MODE_RECORD);

    always_comb
    begin
        if (core >= 8'sd0 && {{(32-8){core[7]}}, core} < $signed(32'(CORES)))
        begin
            slot = SLOT_W'(core[6:0]);
        end
        else
        begin
            slot = SLOT_W'(CORES);
        end
    end

    assign cnt_sel  = wcount_reg[slot[$clog2(SLOTS)-1:0]];
    assign wptr_sel = wptr_reg[slot[$clog2(SLOTS)-1:0]];
    assign rec_we   = in_acc && is_rec && !started_reg && (cnt_sel != trmd_pkg::CNT_MAX);
    assign waddr    = ADDR_W'(slot) * ADDR_W'(RING_DEPTH) + ADDR_W'(wptr_sel);
    assign wdata    = {timestamp, actor, message_type, sender, core, kind};

    logic [CW-1:0] cur_idx;
    assign cur_idx   = cursor_reg[idx_reg[$clog2(SLOTS)-1:0]];
    assign wptr_idx  = wptr_reg[idx_reg[$clog2(SLOTS)-1:0]];
    assign rptr_idx  = rptr_reg[idx_reg[$clog2(SLOTS)-1:0]];
    assign rptr_best = rptr_reg[best_slot_reg[$clog2(SLOTS)-1:0]];
    assign re        = (state_reg == S_SCAN) || (state_reg == S_PICK);
    always_comb
    begin
        if (state_reg == S_PICK)
        begin
            raddr = ADDR_W'(best_slot_reg) * ADDR_W'(RING_DEPTH) + ADDR_W'(rptr_best);
        end
        else
        begin
            raddr = ADDR_W'(idx_reg) * ADDR_W'(RING_DEPTH) + ADDR_W'(rptr_idx);
        end
    end

    trmd_ram #(.WIDTH(trmd_pkg::ENTRY_W), .DEPTH(DEPTH)) u_ring (
        .clk   (clk),
        .we    (rec_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic [CW-1:0] lw, lcur, ldrop, lev;
    logic [CW:0] sev, sdr;
    assign lw    = wcount_reg[idx_reg[$clog2(SLOTS)-1:0]];
    assign lcur  = (lw > RD) ? lw - RD : '0;
    assign ldrop = lcur;
    assign lev   = lw - lcur;
    assign sev   = {1'b0, tot_ev_reg} + {1'b0, lev};
    assign sdr   = {1'b0, tot_dr_reg} + {1'b0, ldrop};

    logic [63:0] rd_ts;
    assign rd_ts = rdata[trmd_pkg::ENTRY_W-1 -: 64];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enable_reg    <= 1'b0;
            started_reg   <= 1'b0;
            done_reg      <= 1'b0;
            tot_ev_reg    <= '0;
            tot_dr_reg    <= '0;
            idx_reg       <= '0;
            scan_pend_reg <= 1'b0;
            pend_slot_reg <= '0;
            best_vld_reg  <= 1'b0;
            best_slot_reg <= '0;
            best_ts_reg   <= '0;
            out_valid     <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                wcount_reg[i] <= '0;
                cursor_reg[i] <= '0;
                end_reg[i]    <= '0;
                wptr_reg[i]   <= '0;
                rptr_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
            if (state_reg == S_EMIT && out_free)
            begin
                out_valid <= 1'b1;
            end
            else if (out_acc)
            begin
                out_valid <= 1'b0;
            end
            if (rec_we)
            begin
                wcount_reg[slot[$clog2(SLOTS)-1:0]] <= cnt_sel + 1'b1;
                wptr_reg[slot[$clog2(SLOTS)-1:0]]   <=
                    (wptr_sel == LAST_POS) ? '0 : wptr_sel + 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && !is_rec && enable_reg && !done_reg)
                    begin
                        idx_reg       <= '0;
                        scan_pend_reg <= 1'b0;
                        best_vld_reg  <= 1'b0;
                        if (!started_reg)
                        begin
                            tot_ev_reg <= '0;
                            tot_dr_reg <= '0;
                            state_reg  <= S_LATCH;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_LATCH:
                begin
                    cursor_reg[idx_reg[$clog2(SLOTS)-1:0]] <= lcur;
                    end_reg[idx_reg[$clog2(SLOTS)-1:0]]    <= lw;
                    // oldest surviving entry sits at the write pointer once wrapped
                    rptr_reg[idx_reg[$clog2(SLOTS)-1:0]]   <= (lw > RD) ? wptr_idx : '0;
                    tot_ev_reg <= sev[CW] ? trmd_pkg::CNT_MAX : sev[CW-1:0];
                    tot_dr_reg <= sdr[CW] ? trmd_pkg::CNT_MAX : sdr[CW-1:0];
                    if (idx_reg == SLOT_W'(SLOTS - 1))
                    begin
                        idx_reg     <= '0;
                        started_reg <= 1'b1;
                        state_reg   <= S_SCAN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (scan_pend_reg && (!best_vld_reg || rd_ts < best_ts_reg))
                    begin
                        best_vld_reg  <= 1'b1;
                        best_slot_reg <= pend_slot_reg;
                        best_ts_reg   <= rd_ts;
                    end
                    if (idx_reg == SLOT_W'(SLOTS))
                    begin
                        state_reg <= S_PICK;
                        scan_pend_reg <= 1'b0;
                    end
                    else
                    begin
                        scan_pend_reg <= cur_idx < end_reg[idx_reg[$clog2(SLOTS)-1:0]];
                        pend_slot_reg <= idx_reg;
                        idx_reg       <= idx_reg + 1'b1;
                    end
                end
                S_PICK:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                        if (best_vld_reg)
                        begin
                            cursor_reg[best_slot_reg[$clog2(SLOTS)-1:0]] <=
                                cursor_reg[best_slot_reg[$clog2(SLOTS)-1:0]] + 1'b1;
                            rptr_reg[best_slot_reg[$clog2(SLOTS)-1:0]] <=
                                (rptr_best == LAST_POS) ? '0 : rptr_best + 1'b1;
                        end
                        else
                        begin
                            done_reg <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EMIT && out_free)
        begin
            is_summary <= !best_vld_reg;
            if (best_vld_reg)
            begin
                {out_time, out_actor, out_message_type, out_sender, out_core, out_kind} <= rdata;
                event_total <= '0;
                drop_total  <= '0;
            end
            else
            begin
                out_time         <= '0;
                out_actor        <= '0;
                out_message_type <= '0;
                out_sender       <= '0;
                out_core         <= '0;
                out_kind         <= '0;
                event_total      <= tot_ev_reg;
                drop_total       <= tot_dr_reg;
            end
        end
    end

    `ASSERT_IMPLIES(a_no_rec_after_start, clk, rst_n, started_reg, !rec_we)
    `ASSERT_NEXT(a_summary_ends, clk, rst_n, out_acc && is_summary, done_reg)
    `ASSERT_IMPLIES(a_busy_stalls, clk, rst_n, state_reg != S_IDLE, in_stall)
endmodule
`default_nettype wire
